// ===== design/brf_pkg.sv =====
// Shared types, codes and command/status bundles for the batch ring FIFO.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps

package brf_pkg;

    // Payload widths fixed by the channel format
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 3;
    localparam int VALUE_FIELDS = 4;
    localparam int VIDX_W       = 2;

    // Operation codes on the request channel
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [COUNT_W-1:0]       count_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture request payload
        logic write;        // store one element at the tail
        logic read;         // read one element at the head
        logic emit_refuse;  // load a refused result
        logic emit_ack;     // load an accepted push result
        logic emit_data;    // load a popped element
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_pop;       // captured request is a pop
        logic fits;         // captured batch can be done in full
        logic final_wr;     // element being written is the last of the batch
        logic batch_done;   // all elements of the batch have been read
        logic out_free;     // output register can take a result this cycle
    } stat_t;

endpackage

// ===== design/brf_if.sv =====
// Request and result channel interfaces for the batch ring FIFO.
// Depends on brf_pkg for the payload types.
`timescale 1ns / 1ps

interface brf_req_if;
    logic            valid;
    logic            ready;
    logic            operation;
    brf_pkg::count_t count;
    brf_pkg::data_t  value_0;
    brf_pkg::data_t  value_1;
    brf_pkg::data_t  value_2;
    brf_pkg::data_t  value_3;

    modport source (output valid, operation, count, value_0, value_1, value_2, value_3,
                    input ready);
    modport sink   (input valid, operation, count, value_0, value_1, value_2, value_3,
                    output ready);
endinterface

interface brf_rsp_if;
    logic           valid;
    logic           ready;
    logic           accepted;
    brf_pkg::data_t popped_value;
    logic           last;

    modport source (output valid, accepted, popped_value, last, input ready);
    modport sink   (input valid, accepted, popped_value, last, output ready);
endinterface

// ===== design/batch_ring_fifo.sv =====
// Top level of the batch ring FIFO: controller plus datapath.
// Depends on brf_pkg, brf_req_if/brf_rsp_if, brf_ctrl and brf_datapath.
//
// Usage:
//   req carries one batch request: operation (push or pop), count 1..MAX_BATCH
//   and up to four push values. rsp returns results: one per push or refused
//   request, count results (oldest first, last on the final) per accepted pop.
//   Capacity is DEPTH-1 words; a request that does not fit completely is
//   refused with {accepted=0, popped_value=0, last=1} and changes nothing.
// Sequencing:
//   req.ready is high while the controller is idle. A request is checked
//   first; a refused one then loads its result, a push writes its elements
//   one by one and then loads one result, and a pop alternates element reads
//   and result loads. This is set by the single write port and the registered
//   read port of the storage memory (one element per write, read plus result
//   load per pop).
// Stalls and reset:
//   Results sit in an output register; a new request is accepted while the
//   last result still waits. While it waits and rsp.ready is low, the
//   controller waits before loading the next result. Reset empties the FIFO
//   (head and tail to zero, no result pending); contents are left undefined.
`timescale 1ns / 1ps

module batch_ring_fifo #(
    parameter int DEPTH     = 32,
    parameter int MAX_BATCH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    brf_req_if.sink   req,
    brf_rsp_if.source rsp
);
    import brf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    brf_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BATCH (MAX_BATCH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_operation     (req.operation),
        .in_count         (req.count),
        .in_value_0       (req.value_0),
        .in_value_1       (req.value_1),
        .in_value_2       (req.value_2),
        .in_value_3       (req.value_3),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_accepted     (rsp.accepted),
        .out_popped_value (rsp.popped_value),
        .out_last         (rsp.last)
    );

endmodule

// ===== design/brf_ctrl.sv =====
// Controller state machine of the batch ring FIFO: sequences check, element
// writes, element reads and result loads. Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  brf_pkg::stat_t stat,
    output brf_pkg::cmd_t  cmd
);
    import brf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_ACK,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.fits)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_refuse = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.is_pop)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                if (stat.final_wr)
                begin
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_data = 1'b1;
                    state_next    = stat.batch_done ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/brf_datapath.sv =====
// Datapath of the batch ring FIFO: storage memory, head/tail pointers, the
// captured request, fit check and the output register. Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_datapath #(
    parameter int DEPTH     = 32,
    parameter int MAX_BATCH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  brf_pkg::cmd_t   cmd,
    output brf_pkg::stat_t  stat,
    input  logic            in_operation,
    input  brf_pkg::count_t in_count,
    input  brf_pkg::data_t  in_value_0,
    input  brf_pkg::data_t  in_value_1,
    input  brf_pkg::data_t  in_value_2,
    input  brf_pkg::data_t  in_value_3,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_accepted,
    output brf_pkg::data_t  out_popped_value,
    output logic            out_last
);
    import brf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CMP_W = PTR_W + 4;
    localparam int LIMIT = (MAX_BATCH < VALUE_FIELDS) ? MAX_BATCH : VALUE_FIELDS;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CMP_W-1:0] cmp_t;

    data_t  mem [DEPTH];
    data_t  rd_data_reg;
    data_t  val_reg [VALUE_FIELDS];
    logic   op_reg;
    count_t count_reg;
    count_t elem_reg;
    ptr_t   head_reg;
    ptr_t   tail_reg;
    logic   out_valid_reg;
    logic   out_accepted_reg;
    data_t  out_value_reg;
    logic   out_last_reg;

    cmp_t used_x;
    cmp_t space_x;
    cmp_t cnt_x;
    logic count_ok;
    logic load_out;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Fill level, free space and the all-or-nothing check
    always_comb
    begin
        if (tail_reg >= head_reg)
        begin
            used_x = CMP_W'(tail_reg) - CMP_W'(head_reg);
        end
        else
        begin
            used_x = CMP_W'(tail_reg) + CMP_W'(DEPTH) - CMP_W'(head_reg);
        end
        space_x  = CMP_W'(DEPTH - 1) - used_x;
        cnt_x    = CMP_W'(count_reg);
        count_ok = (count_reg != '0) && (cnt_x <= CMP_W'(LIMIT));
    end

    assign load_out        = cmd.emit_refuse | cmd.emit_ack | cmd.emit_data;
    assign stat.is_pop     = (op_reg == OP_POP);
    assign stat.fits       = count_ok &&
                             ((op_reg == OP_POP) ? (cnt_x <= used_x) : (cnt_x <= space_x));
    assign stat.final_wr   = ((elem_reg + count_t'(1)) == count_reg);
    assign stat.batch_done = (elem_reg == count_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_operation;
            count_reg  <= in_count;
            val_reg[0] <= in_value_0;
            val_reg[1] <= in_value_1;
            val_reg[2] <= in_value_2;
            val_reg[3] <= in_value_3;
        end
    end

    // Storage: one write port at the tail, one registered read at the head
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[tail_reg] <= val_reg[elem_reg[VIDX_W-1:0]];
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    // Pointers and element counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            elem_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                elem_reg <= '0;
            end
            else if (cmd.write || cmd.read)
            begin
                elem_reg <= elem_reg + count_t'(1);
            end
            if (cmd.write)
            begin
                tail_reg <= ptr_inc(tail_reg);
            end
            if (cmd.read)
            begin
                head_reg <= ptr_inc(head_reg);
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_accepted_reg <= cmd.emit_ack | cmd.emit_data;
            out_value_reg    <= cmd.emit_data ? rd_data_reg : '0;
            out_last_reg     <= cmd.emit_data ? stat.batch_done : 1'b1;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_accepted     = out_accepted_reg;
    assign out_popped_value = out_value_reg;
    assign out_last         = out_last_reg;

    // A result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> stat.out_free)
        else $error("result loaded while output register is stalled");

    // Writes stay within the captured batch
    a_write_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> (elem_reg < count_reg))
        else $error("element write beyond batch count");

    // Head moves only on a read, tail only on a write
    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.read |=> $stable(head_reg))
        else $error("head moved without a read");

    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.write |=> $stable(tail_reg))
        else $error("tail moved without a write");

    // A read happens only inside a batch of nonzero count, before all its elements are read
    a_pop_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> (count_reg != '0) && (elem_reg < count_reg))
        else $error("read outside an accepted pop");

endmodule

// ===== sim/tb_batch_ring_fifo.sv =====
// Self-checking testbench for batch_ring_fifo: directed and random batch requests.
// Depends on brf_pkg and brf_req_if/brf_rsp_if; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module tb_batch_ring_fifo;
    import brf_pkg::*;

    localparam int DEPTH       = 32;
    localparam int MAX_BATCH   = 4;
    localparam int BATCH_LIMIT = (MAX_BATCH < VALUE_FIELDS) ? MAX_BATCH : VALUE_FIELDS;
    localparam int RANDOM_REQS = 46;     // per idling phase
    localparam int HOLD_CYCLES = 300;    // long receiver stall

    // One batch request as it travels on the request channel
    typedef struct packed {
        logic                                operation;
        count_t                              count;
        logic [VALUE_FIELDS-1:0][DATA_W-1:0] values;
    } batch_req_t;

    // One result as it travels on the result channel
    typedef struct packed {
        logic  accepted;
        data_t popped_value;
        logic  last;
    } fifo_result_t;

    // Ring model plus the queue of results still owed by the block
    class fifo_scoreboard;
        data_t        ring [DEPTH];
        int           head_idx;
        int           tail_idx;
        fifo_result_t pending_results [$];
        int           mismatches;

        function new();
            head_idx   = 0;
            tail_idx   = 0;
            mismatches = 0;
        endfunction

        function int stored();
            return (tail_idx + DEPTH - head_idx) % DEPTH;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        // Accepted request: update the ring and queue the results it causes
        function void note_request(batch_req_t r);
            int           used;
            int           space;
            int           n;
            fifo_result_t res;
            used = stored();
            space = DEPTH - 1 - used;
            n = int'(r.count);
            res.accepted     = 1'b0;
            res.popped_value = '0;
            res.last         = 1'b1;
            // zero count, oversize batch, no room, too few stored: all refused
            if (n == 0 || n > BATCH_LIMIT ||
                (r.operation == OP_PUSH && n > space) ||
                (r.operation == OP_POP && n > used))
            begin
                pending_results.push_back(res);
                return;
            end
            if (r.operation == OP_PUSH)
            begin
                for (int i = 0; i < n; i++)
                begin
                    ring[(tail_idx + i) % DEPTH] = data_t'(r.values[i]);
                end
                tail_idx = (tail_idx + n) % DEPTH;
                res.accepted = 1'b1;
                pending_results.push_back(res);
            end
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    res.accepted     = 1'b1;
                    res.popped_value = ring[(head_idx + i) % DEPTH];
                    res.last         = (i == n - 1);
                    pending_results.push_back(res);
                end
                head_idx = (head_idx + n) % DEPTH;
            end
        endfunction

        // Accepted result: compare with the oldest expectation
        function void check_result(fifo_result_t got);
            fifo_result_t want;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected result acc=%0b val=%0d last=%0b",
                             $realtime, got.accepted, got.popped_value, got.last);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.accepted !== want.accepted || got.popped_value !== want.popped_value ||
                got.last !== want.last)
            begin
                if (mismatches < 10)
                    $display("%0t: exp acc=%0b val=%0d last=%0b, got acc=%0b val=%0d last=%0b",
                             $realtime, want.accepted, want.popped_value, want.last,
                             got.accepted, got.popped_value, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             hold_left;
    bit             fill_bias;
    fifo_scoreboard sb;
    fifo_result_t   rsp_seen;

    brf_req_if req_ch ();
    brf_rsp_if rsp_ch ();

    batch_ring_fifo #(
        .DEPTH     (DEPTH),
        .MAX_BATCH (MAX_BATCH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Run limit
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: long hold-off first, otherwise random idling
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            hold_left    = hold_left - 1;
        end
        else
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_seen.accepted     = rsp_ch.accepted;
            rsp_seen.popped_value = rsp_ch.popped_value;
            rsp_seen.last         = rsp_ch.last;
            sb.check_result(rsp_seen);
        end
    end

    function automatic batch_req_t make_req(logic op, int n, logic [31:0] v0, logic [31:0] v1,
                                            logic [31:0] v2, logic [31:0] v3);
        batch_req_t r;
        r.operation = op;
        r.count     = count_t'(n);
        r.values[0] = v0;
        r.values[1] = v1;
        r.values[2] = v2;
        r.values[3] = v3;
        return r;
    endfunction

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(15))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'h0000_0000;
            3:       v = 32'hffff_ffff;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Mostly well-formed batches steered between full and empty, some bad counts
    function automatic batch_req_t random_request(bit push_heavy);
        batch_req_t r;
        int         n;
        logic       op;
        if ($urandom_range(99) < 8)
        begin
            case ($urandom_range(3))
                0:       n = 0;
                1:       n = 5;
                2:       n = 6;
                default: n = 7;
            endcase
            op = logic'($urandom_range(1));
        end
        else
        begin
            n = $urandom_range(BATCH_LIMIT, 1);
            if (push_heavy)
                op = ($urandom_range(99) < 75) ? OP_PUSH : OP_POP;
            else
                op = ($urandom_range(99) < 25) ? OP_PUSH : OP_POP;
        end
        r = make_req(op, n, random_value(), random_value(), random_value(), random_value());
        return r;
    endfunction

    // Offer one request from a falling edge; returns at the falling edge after acceptance
    task automatic send_req(batch_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.operation = r.operation;
        req_ch.count     = r.count;
        req_ch.value_0   = r.values[0];
        req_ch.value_1   = r.values[1];
        req_ch.value_2   = r.values[2];
        req_ch.value_3   = r.values[3];
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(r);
        @(negedge clk);
    endtask

    // Main sequence
    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_PUSH;
        req_ch.count     = '0;
        req_ch.value_0   = '0;
        req_ch.value_1   = '0;
        req_ch.value_2   = '0;
        req_ch.value_3   = '0;
        rsp_ch.ready     = 1'b0;
        hold_left        = 0;
        send_idle_pct    = 29;
        recv_idle_pct    = 63;
        fill_bias        = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: refusals on empty, bad counts, extremes, fill to capacity
        send_req(make_req(OP_POP, 1, 0, 0, 0, 0));
        send_req(make_req(OP_PUSH, 0, 32'h1234_5678, 0, 0, 0));
        send_req(make_req(OP_POP, 0, 0, 0, 0, 0));
        send_req(make_req(OP_PUSH, 5, 1, 2, 3, 4));
        send_req(make_req(OP_POP, 6, 0, 0, 0, 0));
        send_req(make_req(OP_PUSH, 7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff));
        send_req(make_req(OP_PUSH, 4, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                          32'hffff_ffff));
        send_req(make_req(OP_POP, 2, 0, 0, 0, 0));
        send_req(make_req(OP_POP, 3, 0, 0, 0, 0));
        send_req(make_req(OP_POP, 2, 0, 0, 0, 0));
        for (int i = 0; i < 7; i++)
            send_req(make_req(OP_PUSH, 4, $urandom, $urandom, $urandom, $urandom));
        // 28 stored: four more do not fit, three do, then the ring is full
        send_req(make_req(OP_PUSH, 4, $urandom, $urandom, $urandom, $urandom));
        send_req(make_req(OP_PUSH, 3, $urandom, $urandom, $urandom, $urandom));
        send_req(make_req(OP_PUSH, 1, $urandom, 0, 0, 0));
        send_req(make_req(OP_POP, 4, 0, 0, 0, 0));
        fill_bias = 1'b0;

        // Random: three idling phases, the last one opens with a long receiver stall
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 29;
                    recv_idle_pct = 63;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_idle_pct = 29;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    @(posedge clk);
                    hold_left = HOLD_CYCLES;
                    @(negedge clk);
                    fill_bias = 1'b1;
                end
            endcase
            for (int k = 0; k < RANDOM_REQS; k++)
            begin
                if (sb.stored() >= DEPTH - 4)
                    fill_bias = 1'b0;
                else if (sb.stored() <= 3)
                    fill_bias = 1'b1;
                send_req(random_request(fill_bias));
            end
        end
        req_ch.valid = 1'b0;

        // Drain and let the block settle
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
